// ===== rtl/core/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the circular convolver core.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int MAX_LEN_LOG2 = 10;
  localparam int MAX_LEN      = 1 << MAX_LEN_LOG2;
  localparam int ADDR_W       = MAX_LEN_LOG2;
  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int RESULT_W     = 42;
  localparam int LOG_W        = 4;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic [LOG_W-1:0] LEN_LOG2_RST = LOG_W'(MAX_LEN_LOG2);

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_LEN_LOG2 = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_DRAIN,
    ST_READ
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              load_we;
    logic              issue;
    logic [ADDR_W-1:0] n;
    logic [ADDR_W-1:0] k;
    logic              first_k;
    logic              last_k;
    logic              rd_en;
    logic              out_ok;
  } cmd_t;

endpackage

// ===== rtl/core/fcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer: store clearing, item accept, MAC sweep, read response, config.
// ----------------------------------------------------------------------------
module fcc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [fcc_pkg::ADDR_W-1:0]    in_index,
  input  logic                          in_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [fcc_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [fcc_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output logic [fcc_pkg::ADDR_W-1:0]    len_mask,
  output fcc_pkg::cmd_t                 cmd,
  output logic                          out_strobe,
  output logic [fcc_pkg::ADDR_W-1:0]    out_result_index,
  output logic                          out_valid_res
);
  import fcc_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [LOG_W-1:0]  len_r;
  logic              ready_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              rd_ok_r;
  logic [LOG_W-1:0]  eff_log;
  logic              accept;
  logic              in_range;
  logic              cfg_wr;
  logic              last_k;

  // effective length, clamped to 2..MAX_LEN
  always_comb begin
    if (len_r == '0) begin
      eff_log = LOG_W'(1);
    end else if (len_r > LOG_W'(MAX_LEN_LOG2)) begin
      eff_log = LOG_W'(MAX_LEN_LOG2);
    end else begin
      eff_log = len_r;
    end
  end
  assign len_mask = ADDR_W'(((ADDR_W+1)'(1) << eff_log) - (ADDR_W+1)'(1));

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ((in_index & ~len_mask) == '0);
  assign last_k   = (k_r == len_mask);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_LEN_LOG2) ? PDATA_W'(len_r) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            state_nxt = ST_READ;
          end else if (in_last) begin
            state_nxt = ST_CONV;
            n_nxt     = '0;
            k_nxt     = '0;
          end
        end
      end
      ST_CONV: begin
        k_nxt = last_k ? '0 : k_r + ADDR_W'(1);
        if (last_k) begin
          n_nxt = n_r + ADDR_W'(1);
          if (n_r == len_mask) begin
            state_nxt = ST_DRAIN;
            drain_nxt = '0;
          end
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) state_nxt = ST_IDLE;
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.clr_addr = cnt_r;
    cmd.n        = n_r;
    cmd.k        = k_r;
    cmd.first_k  = (k_r == '0);
    cmd.last_k   = last_k;
    cmd.out_ok   = rd_ok_r;
    out_strobe   = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        cmd.load_we = accept && (in_op == OP_LOAD) && in_range;
        cmd.rd_en   = accept && (in_op == OP_READ);
      end
      ST_CONV:  cmd.issue = 1'b1;
      ST_DRAIN: ;
      ST_READ:  out_strobe = 1'b1;
      default: ;
    endcase
  end

  assign out_result_index = rd_idx_r;
  assign out_valid_res    = rd_ok_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      n_r     <= '0;
      k_r     <= '0;
      drain_r <= '0;
      len_r   <= LEN_LOG2_RST;
      ready_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_LEN_LOG2) begin
        len_r   <= cfg_pwdata[LOG_W-1:0];
        ready_r <= 1'b0;
      end else if (state_r == ST_DRAIN && state_nxt == ST_IDLE) begin
        ready_r <= 1'b1;
      end
      if (cmd.rd_en) rd_ok_r <= ready_r && in_range;
    end
  end

  // read index echo
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_idx_r <= in_index;
  end

endmodule

// ===== rtl/core/fcc_datapath.sv =====
// ----------------------------------------------------------------------------
// fcc_datapath
// Sample stores, MAC pipeline (read, multiply, accumulate) and result store.
// ----------------------------------------------------------------------------
module fcc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fcc_pkg::cmd_t                        cmd,
  input  logic [fcc_pkg::ADDR_W-1:0]           len_mask,
  input  logic [fcc_pkg::ADDR_W-1:0]           in_index,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_b,
  output logic signed [fcc_pkg::RESULT_W-1:0]  out_result
);
  import fcc_pkg::*;

  logic signed [SAMPLE_W-1:0] a_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] b_mem [MAX_LEN];
  logic signed [RESULT_W-1:0] res_mem [MAX_LEN];

  logic [ADDR_W-1:0]          j_addr;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic signed [SAMPLE_W-1:0] wr_a, wr_b;
  logic signed [SAMPLE_W-1:0] a_rd_r, b_rd_r;
  logic                       s1_v_r, s1_first_r, s1_last_r;
  logic [ADDR_W-1:0]          s1_n_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       s2_v_r, s2_first_r, s2_last_r;
  logic [ADDR_W-1:0]          s2_n_r;
  logic signed [RESULT_W-1:0] acc_r;
  logic signed [RESULT_W-1:0] sum;
  logic signed [RESULT_W-1:0] res_rd_r;

  // partner index (n - k) mod L
  assign j_addr = (cmd.n - cmd.k) & len_mask;

  // store write: clearing pass or load
  assign wr_en   = cmd.clr_we || cmd.load_we;
  assign wr_addr = cmd.clr_we ? cmd.clr_addr : in_index;
  assign wr_a    = cmd.clr_we ? '0 : in_sample_a;
  assign wr_b    = cmd.clr_we ? '0 : in_sample_b;

  always_ff @(posedge clk) begin
    if (wr_en) a_mem[wr_addr] <= wr_a;
    a_rd_r <= a_mem[cmd.k];
  end

  always_ff @(posedge clk) begin
    if (wr_en) b_mem[wr_addr] <= wr_b;
    b_rd_r <= b_mem[j_addr];
  end

  // accumulate
  assign sum = (s2_first_r ? '0 : acc_r) + RESULT_W'(prod_r);

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first_k;
    s1_last_r  <= cmd.last_k;
    s1_n_r     <= cmd.n;
    prod_r     <= a_rd_r * b_rd_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_n_r     <= s1_n_r;
    if (s2_v_r) acc_r <= sum;
  end

  // result store
  always_ff @(posedge clk) begin
    if (s2_v_r && s2_last_r) res_mem[s2_n_r] <= sum;
    if (cmd.rd_en) res_rd_r <= res_mem[in_index];
  end

  assign out_result = cmd.out_ok ? res_rd_r : '0;

endmodule

// ===== rtl/core/fft_circular_convolver_core.sv =====
// ----------------------------------------------------------------------------
// fft_circular_convolver_core
// Exact circular convolution of two 16-bit blocks of up to 1024 samples.
// ----------------------------------------------------------------------------
// After reset the sample stores are zeroed with busy high. A load with last
// runs L*L multiply-accumulates on one multiplier, one per cycle, then lets
// the pipeline drain before busy falls. A read puts its result on the
// out_ ports for one cycle under out_strobe; the receiver cannot stall and
// must take it then. Items are accepted only while busy is low; configure
// only while idle.
module fft_circular_convolver_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [fcc_pkg::ADDR_W-1:0]           in_index,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_b,
  input  logic                                 in_last,
  output logic                                 out_strobe,
  output logic signed [fcc_pkg::RESULT_W-1:0]  out_result,
  output logic [fcc_pkg::ADDR_W-1:0]           out_result_index,
  output logic                                 out_valid_res,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0]          cfg_paddr,
  input  logic [fcc_pkg::PDATA_W-1:0]          cfg_pwdata,
  output logic [fcc_pkg::PDATA_W-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);
  import fcc_pkg::*;

  cmd_t              cmd;
  logic [ADDR_W-1:0] len_mask;

  fcc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_index         (in_index),
    .in_last          (in_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .len_mask         (len_mask),
    .cmd              (cmd),
    .out_strobe       (out_strobe),
    .out_result_index (out_result_index),
    .out_valid_res    (out_valid_res)
  );

  fcc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .len_mask    (len_mask),
    .in_index    (in_index),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .out_result  (out_result)
  );

endmodule

// ===== bench/fcc_checker.sv =====
// ----------------------------------------------------------------------------
// fcc_checker
// Scoreboard for the circular convolver. It follows register writes and
// accepted items, keeps its own copy of the sample stores, computes the
// convolution directly when a load with last arrives, and checks each
// strobed read result against the oldest pending read.
// ----------------------------------------------------------------------------
module fcc_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_op,
  input  logic [fcc_pkg::ADDR_W-1:0]           in_index,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]  in_sample_b,
  input  logic                                 in_last,
  input  logic                                 out_strobe,
  input  logic signed [fcc_pkg::RESULT_W-1:0]  out_result,
  input  logic [fcc_pkg::ADDR_W-1:0]           out_result_index,
  input  logic                                 out_valid_res,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0]          cfg_paddr,
  input  logic [fcc_pkg::PDATA_W-1:0]          cfg_pwdata,
  input  logic                                 cfg_pready,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcc_pkg::*;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic [ADDR_W-1:0]          index;
    logic                       valid_res;
  } conv_read_t;

  logic [LOG_W-1:0]           len_log2;
  logic                       conv_ready;
  logic signed [SAMPLE_W-1:0] a_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] b_mem [MAX_LEN];
  logic signed [RESULT_W-1:0] conv_mem [MAX_LEN];
  conv_read_t                 read_q [$];

  // block length after clamping the register
  function automatic int block_len(logic [LOG_W-1:0] lg);
    if (lg == 0) return 2;
    if (lg > MAX_LEN_LOG2) return MAX_LEN;
    return 1 << lg;
  endfunction

  // direct circular convolution over the first len samples
  task automatic run_convolution(int len);
    longint acc;
    for (int n = 0; n < len; n++) begin
      acc = 0;
      for (int k = 0; k < len; k++)
        acc += longint'(a_mem[k]) * longint'(b_mem[(n + len - k) % len]);
      conv_mem[n] = acc[RESULT_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    conv_read_t got, want;
    int len;
    if (!rst_n) begin
      len_log2   = LEN_LOG2_RST;
      conv_ready = 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      read_q.delete();
      fail_count <= 0;
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_LEN_LOG2) begin
        len_log2   = cfg_pwdata[LOG_W-1:0];
        conv_ready = 1'b0;
      end
      // result check against the oldest pending read
      if (out_strobe) begin
        got = '{out_result, out_result_index, out_valid_res};
        if (read_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = read_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected res=%0d idx=%0d ok=%0b got res=%0d idx=%0d ok=%0b",
                     $time, want.result, want.index, want.valid_res,
                     got.result, got.index, got.valid_res);
            fail_count <= fail_count + 1;
          end
        end
      end
      // accepted item
      if (start && !busy) begin
        len = block_len(len_log2);
        if (in_op == OP_LOAD) begin
          if (in_index < len) begin
            a_mem[in_index] = in_sample_a;
            b_mem[in_index] = in_sample_b;
          end
          if (in_last) begin
            run_convolution(len);
            conv_ready = 1'b1;
          end
        end else if (conv_ready && in_index < len) begin
          read_q.push_back('{conv_mem[in_index], in_index, 1'b1});
        end else begin
          read_q.push_back('{'0, in_index, 1'b0});
        end
      end
    end
    pending <= read_q.size();
  end

endmodule

// ===== bench/fft_circular_convolver_core_test.sv =====
// ----------------------------------------------------------------------------
// fft_circular_convolver_core_test
// Stimulus and verdict for the circular convolver: directed corner items,
// one full-length block of extreme samples, then random load/read
// sequences over many lengths with random gaps between items.
// ----------------------------------------------------------------------------
module fft_circular_convolver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fcc_pkg::*;

  localparam int IDLE_LIMIT = 5_000_000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_op;
  logic [ADDR_W-1:0]          in_index;
  logic signed [SAMPLE_W-1:0] in_sample_a;
  logic signed [SAMPLE_W-1:0] in_sample_b;
  logic                       in_last;
  logic                       out_strobe;
  logic signed [RESULT_W-1:0] out_result;
  logic [ADDR_W-1:0]          out_result_index;
  logic                       out_valid_res;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [PADDR_W-1:0]         cfg_paddr;
  logic [PDATA_W-1:0]         cfg_pwdata;
  logic [PDATA_W-1:0]         cfg_prdata;
  logic                       cfg_pready;
  int                         fail_count;
  int                         pending;
  int                         idle_cycles;
  int                         item_count;
  bit                         burst;

  fft_circular_convolver_core dut (.*);

  fcc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles with no accepted item, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(logic op, int idx, logic signed [SAMPLE_W-1:0] a,
                           logic signed [SAMPLE_W-1:0] b, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_index    <= ADDR_W'(idx);
    in_sample_a <= a;
    in_sample_b <= b;
    in_last     <= last;
    do @(posedge clk); while (busy);
    item_count++;
  endtask

  task automatic read_item(int idx);
    send_item(OP_READ, idx, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
              1'($urandom_range(0, 1)));
  endtask

  // stop sending and let every pending result and computation finish
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(int addr, logic [PDATA_W-1:0] data);
    settle();
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= PADDR_W'(addr);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int lg, len, nreads;
    start       = 1'b0;
    in_op       = OP_LOAD;
    in_index    = '0;
    in_sample_a = '0;
    in_sample_b = '0;
    in_last     = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    idle_cycles = 0;
    item_count  = 0;
    burst       = 1'b0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset length, nothing computed yet
    read_item(0);
    send_item(OP_LOAD, 0, -16'sd32768, 16'sd32767, 1'b0);
    send_item(OP_LOAD, 1023, 16'sd32767, -16'sd32768, 1'b0);
    read_item(1023);
    // shortest block; last on a load past the length still computes
    write_reg(REG_LEN_LOG2 * 4, 32'hFFFF_FFF1);
    send_item(OP_LOAD, 0, -16'sd32768, -16'sd32768, 1'b0);
    send_item(OP_LOAD, 1, 16'sd32767, -16'sd32768, 1'b0);
    send_item(OP_LOAD, 700, 16'sd1, 16'sd1, 1'b1);
    read_item(0);
    read_item(1);
    read_item(2);
    // write to an unmapped register leaves results intact
    write_reg(4, 32'h0000_0003);
    read_item(1);
    // zero acts as one and invalidates the results
    write_reg(REG_LEN_LOG2 * 4, 32'h0);
    read_item(0);
    send_item(OP_LOAD, 1, 16'sd0, 16'sd5, 1'b1);
    read_item(0);
    read_item(1);

    // saturated length: full block of most negative samples
    write_reg(REG_LEN_LOG2 * 4, 32'hF);
    burst = 1'b1;
    for (int i = 0; i < MAX_LEN; i++)
      send_item(OP_LOAD, i, -16'sd32768, -16'sd32768, i == MAX_LEN - 1);
    burst = 1'b0;
    read_item(0);
    read_item(517);
    read_item(1023);
    settle();

    // random sequences over many lengths
    while (item_count < 1300) begin
      lg = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 5);
      write_reg(REG_LEN_LOG2 * 4, {28'($urandom()), 4'(lg)});
      len = (lg == 0) ? 2 : (lg > 10 ? MAX_LEN : (1 << lg));
      for (int r = 0; r < 3; r++) begin
        burst = ($urandom_range(0, 3) == 0);
        if (lg <= 5) begin
          // well-formed block: fill, compute, read back
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
              send_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                        pick_sample(), pick_sample(), 1'b0);
            if ($urandom_range(0, 5) != 0)
              send_item(OP_LOAD, i, pick_sample(), pick_sample(), 1'b0);
          end
          send_item(OP_LOAD, $urandom_range(0, 1023), pick_sample(), pick_sample(), 1'b1);
        end
        nreads = $urandom_range(1, 2 * len > 40 ? 40 : 2 * len);
        for (int i = 0; i < nreads; i++)
          read_item(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, len - 1));
        // plain loads keep earlier results
        if ($urandom_range(0, 1) == 0) begin
          send_item(OP_LOAD, $urandom_range(0, 1023), pick_sample(), pick_sample(), 1'b0);
          read_item($urandom_range(0, len - 1));
        end
        if (r == 1) settle();
      end
    end
    burst = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
